/* src/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, codes and the single-byte step function of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int CpW = 21;
  localparam logic [CpW-1:0] ReplChar = 21'h00FFFD;

  typedef enum logic [3:0] {
    ST_ACCEPT   = 4'd0,
    ST_NEED1    = 4'd1,
    ST_NEED2    = 4'd2,
    ST_AFTER_E0 = 4'd3,
    ST_AFTER_ED = 4'd4,
    ST_NEED3    = 4'd5,
    ST_AFTER_F0 = 4'd6,
    ST_AFTER_F4 = 4'd7
  } dec_state_t;

  typedef enum logic [1:0] {
    FEED_NONE   = 2'd0,
    FEED_CODE   = 2'd1,
    FEED_REJECT = 2'd2
  } feed_kind_t;

  typedef struct packed {
    feed_kind_t       kind;
    logic [CpW-1:0]   cp;
    dec_state_t       state;
    logic [CpW-1:0]   partial;
  } feed_res_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           repl;
    logic           last;
  } result_t;

  // what one input byte does: up to two results and the new decoder state
  typedef struct packed {
    logic [1:0]     n;
    result_t        r0;
    result_t        r1;
    dec_state_t     state;
    logic [CpW-1:0] partial;
  } step_t;

  function automatic feed_res_t feed_byte(dec_state_t st, logic [CpW-1:0] partial,
                                          logic [7:0] b);
    feed_res_t  res;
    logic [7:0] lo;
    logic [7:0] hi;
    dec_state_t nxt;
    logic [CpW-1:0] acc;
    res  = '{kind: FEED_NONE, cp: '0, state: ST_ACCEPT, partial: '0};
    lo   = 8'h80;
    hi   = 8'hBF;
    nxt  = ST_ACCEPT;
    acc  = '0;
    case (st)
      ST_NEED1:    nxt = ST_ACCEPT;
      ST_NEED2:    nxt = ST_NEED1;
      ST_AFTER_E0: begin
        lo  = 8'hA0;
        nxt = ST_NEED1;
      end
      ST_AFTER_ED: begin
        hi  = 8'h9F;
        nxt = ST_NEED1;
      end
      ST_NEED3:    nxt = ST_NEED2;
      ST_AFTER_F0: begin
        lo  = 8'h90;
        nxt = ST_NEED2;
      end
      ST_AFTER_F4: begin
        hi  = 8'h8F;
        nxt = ST_NEED2;
      end
      default:     nxt = ST_ACCEPT;
    endcase
    if (st == ST_ACCEPT || st > ST_AFTER_F4) begin
      // lead byte
      if (b < 8'h80) begin
        res.kind = FEED_CODE;
        res.cp   = {13'd0, b};
      end else if (b < 8'hC2 || b > 8'hF4) begin
        res.kind = FEED_REJECT;
      end else if (b < 8'hE0) begin
        res.partial = {16'd0, b[4:0]};
        res.state   = ST_NEED1;
      end else if (b < 8'hF0) begin
        res.partial = {17'd0, b[3:0]};
        res.state   = (b == 8'hE0) ? ST_AFTER_E0 : (b == 8'hED) ? ST_AFTER_ED : ST_NEED2;
      end else begin
        res.partial = {18'd0, b[2:0]};
        res.state   = (b == 8'hF0) ? ST_AFTER_F0 : (b == 8'hF4) ? ST_AFTER_F4 : ST_NEED3;
      end
    end else if (b < lo || b > hi) begin
      res.kind = FEED_REJECT;
    end else begin
      acc = {partial[CpW-7:0], b[5:0]};
      if (nxt == ST_ACCEPT) begin
        res.kind = FEED_CODE;
        res.cp   = acc;
      end else begin
        res.state   = nxt;
        res.partial = acc;
      end
    end
    return res;
  endfunction

endpackage

/* src/u8d_core.sv */
// ----------------------------------------------------------------------------
// u8d_core
// Decodes one byte against the current decoder state, including the retry
// of a byte that broke a sequence.
// ----------------------------------------------------------------------------
module u8d_core
  import u8d_pkg::*;
(
  input  dec_state_t     state,
  input  logic [CpW-1:0] partial,
  input  logic [7:0]     data_byte,
  input  logic           end_of_input,
  output step_t          step
);

  feed_res_t first;
  feed_res_t retry;
  logic      was_mid;

  assign was_mid = (state != ST_ACCEPT) && (state <= ST_AFTER_F4);
  assign first   = feed_byte(state, partial, data_byte);
  assign retry   = feed_byte(ST_ACCEPT, '0, data_byte);

  always_comb begin
    step         = '0;
    step.state   = first.state;
    step.partial = first.partial;
    case (first.kind)
      FEED_CODE: begin
        step.n  = 2'd1;
        step.r0 = '{cp: first.cp, repl: 1'b0, last: 1'b1};
      end
      FEED_REJECT: begin
        step.n  = 2'd1;
        step.r0 = '{cp: ReplChar, repl: 1'b1, last: 1'b1};
        if (was_mid) begin
          // broken sequence: the byte is decoded again from the start
          step.state   = retry.state;
          step.partial = retry.partial;
          if (retry.kind != FEED_NONE) begin
            step.n       = 2'd2;
            step.r0.last = 1'b0;
            step.r1.cp   = (retry.kind == FEED_CODE) ? retry.cp : ReplChar;
            step.r1.repl = (retry.kind != FEED_CODE);
            step.r1.last = 1'b1;
          end
        end
      end
      default: step.n = 2'd0;
    endcase
    if (end_of_input) begin
      step.state   = ST_ACCEPT;
      step.partial = '0;
    end
  end

endmodule

/* src/utf8_decode_with_replacement.sv */
// ----------------------------------------------------------------------------
// utf8_decode_with_replacement
// Strict UTF-8 decoder that emits U+FFFD for invalid input.
// ----------------------------------------------------------------------------
// One byte per beat goes in on s_*, decoded code points come out on m_*, one
// per beat. The block takes a byte every cycle while the output side keeps up;
// a taken byte passes the input register and then the two-entry result slot
// before it reaches the output. A byte that breaks a sequence can give two
// results: U+FFFD and then the result of the same byte decoded from the start.
// Such a byte always follows one that gave at most one result, so the result slot
// keeps the rate at one byte per cycle as long as the output side takes one
// beat per cycle. tlast on the input marks the end of the stream and drops any
// unfinished sequence silently; tlast on the output marks the final result of a byte.
module utf8_decode_with_replacement
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_tuser,   // is_replacement
  output logic        m_tlast    // last_of_run
);

  // input register
  logic           in_valid;
  logic [7:0]     in_byte;
  logic           in_eoi;

  // decoder state
  dec_state_t     dec_state;
  logic [CpW-1:0] partial;

  // result slot
  result_t        slot [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  logic [1:0]     count_next;

  step_t          step;
  logic           pop;
  logic           consume;
  logic [2:0]     room_need;

  u8d_core u_core (
    .state        (dec_state),
    .partial      (partial),
    .data_byte    (in_byte),
    .end_of_input (in_eoi),
    .step         (step)
  );

  assign pop       = m_tvalid && m_tready;
  assign room_need = {1'b0, count} - {2'b00, pop} + {1'b0, step.n};
  assign consume   = in_valid && (room_need <= 3'd2);
  assign s_tready  = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eoi  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_state <= ST_ACCEPT;
      partial   <= '0;
    end else if (consume) begin
      dec_state <= step.state;
      partial   <= step.partial;
    end
  end

  always_comb begin
    count_next = count;
    if (consume) begin
      count_next = room_need[1:0];
    end else if (pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      count <= count_next;
      if (pop) begin
        rptr <= ~rptr;
      end
      if (consume) begin
        wptr <= wptr ^ step.n[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && step.n != 2'd0) begin
      slot[wptr] <= step.r0;
    end
    if (consume && step.n == 2'd2) begin
      slot[~wptr] <= step.r1;
    end
  end

  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = {3'd0, slot[rptr].cp};
  assign m_tuser  = slot[rptr].repl;
  assign m_tlast  = slot[rptr].last;

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("result slot count out of range");

  a_double_from_empty: assert property (@(posedge clk) disable iff (rst)
    consume && step.n == 2'd2 |-> count == 2'd0 || (count == 2'd1 && pop))
    else $error("double result written without room");

  a_eoi_resets: assert property (@(posedge clk) disable iff (rst)
    consume && in_eoi |=> dec_state == ST_ACCEPT && partial == '0)
    else $error("decoder not reset after end of input");

  a_ptr_sync: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 || count == 2'd2 |-> wptr == rptr)
    else $error("slot pointers disagree with count");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the strict UTF-8 decoder with U+FFFD replacement.
// Directed edge sequences, then random well-formed, truncated, out-of-range
// and noise bytes with random gaps on both streams. A scoreboard predicts each
// result beat from the accepted bytes and compares it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import u8d_pkg::*;

  localparam int IdleLimit = 5000;
  localparam int ByteCount = 1300;

  // bit 8 is end_of_input
  localparam logic [8:0] Directed [31] = '{
    9'h000, 9'h07F, 9'h080, 9'h0C1, 9'h0F5, 9'h0FF,
    9'h0C2, 9'h080,
    9'h0E0, 9'h0A0, 9'h080,
    9'h0E0, 9'h09F,
    9'h0ED, 9'h0A0,
    9'h0F4, 9'h090,
    9'h0F0, 9'h090, 9'h080, 9'h080,
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
    9'h0E1, 9'h0C2, 9'h041,
    9'h0F1, 9'h180,
    9'h080
  };
  localparam logic [7:0] RangedLeads [4] = '{8'hE0, 8'hED, 8'hF0, 8'hF4};
  localparam logic [CpW-1:0] EdgeScalars [10] = '{
    21'h000000, 21'h00007F, 21'h000080, 21'h0007FF, 21'h000800,
    21'h00D7FF, 21'h00E000, 21'h00FFFF, 21'h010000, 21'h10FFFF
  };

  class cp_scoreboard;
    typedef struct {
      logic [CpW-1:0] cp;
      logic           repl;
      logic           last;
    } cp_beat_t;

    dec_state_t     cur_state;
    logic [CpW-1:0] acc_code;
    cp_beat_t       pending_cps[$];
    int             fails;

    function new();
      cur_state = ST_ACCEPT;
      acc_code  = '0;
      fails     = 0;
    endfunction

    function void flag(string what);
      fails++;
      if (fails <= 10) $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    // one pass of the byte through the decoder; leaves it in accept on reject
    function feed_kind_t take_byte(logic [7:0] b, output logic [CpW-1:0] cp);
      logic [7:0] lo;
      logic [7:0] hi;
      dec_state_t nxt;
      lo  = 8'h80;
      hi  = 8'hBF;
      nxt = ST_ACCEPT;
      cp  = '0;
      if (cur_state == ST_ACCEPT || cur_state > ST_AFTER_F4) begin
        acc_code  = '0;
        cur_state = ST_ACCEPT;
        if (b < 8'h80) begin
          cp = {13'd0, b};
          return FEED_CODE;
        end
        if (b < 8'hC2 || b > 8'hF4) return FEED_REJECT;
        if (b < 8'hE0) begin
          acc_code  = {16'd0, b[4:0]};
          cur_state = ST_NEED1;
        end else if (b < 8'hF0) begin
          acc_code  = {17'd0, b[3:0]};
          cur_state = (b == 8'hE0) ? ST_AFTER_E0 : (b == 8'hED) ? ST_AFTER_ED : ST_NEED2;
        end else begin
          acc_code  = {18'd0, b[2:0]};
          cur_state = (b == 8'hF0) ? ST_AFTER_F0 : (b == 8'hF4) ? ST_AFTER_F4 : ST_NEED3;
        end
        return FEED_NONE;
      end
      case (cur_state)
        ST_NEED1:    nxt = ST_ACCEPT;
        ST_NEED2:    nxt = ST_NEED1;
        ST_AFTER_E0: begin
          lo  = 8'hA0;
          nxt = ST_NEED1;
        end
        ST_AFTER_ED: begin
          hi  = 8'h9F;
          nxt = ST_NEED1;
        end
        ST_NEED3:    nxt = ST_NEED2;
        ST_AFTER_F0: begin
          lo  = 8'h90;
          nxt = ST_NEED2;
        end
        default: begin
          hi  = 8'h8F;
          nxt = ST_NEED2;
        end
      endcase
      if (b < lo || b > hi) begin
        acc_code  = '0;
        cur_state = ST_ACCEPT;
        return FEED_REJECT;
      end
      acc_code  = {acc_code[CpW-7:0], b[5:0]};
      cur_state = nxt;
      if (nxt == ST_ACCEPT) begin
        cp       = acc_code;
        acc_code = '0;
        return FEED_CODE;
      end
      return FEED_NONE;
    endfunction

    function void note_byte(logic [7:0] b, logic eoi);
      bit             was_mid;
      feed_kind_t     kind;
      logic [CpW-1:0] cp;
      cp_beat_t       first;
      was_mid = cur_state != ST_ACCEPT && cur_state <= ST_AFTER_F4;
      kind    = take_byte(b, cp);
      if (kind == FEED_CODE) begin
        pending_cps.push_back('{cp, 1'b0, 1'b1});
      end else if (kind == FEED_REJECT) begin
        first = '{ReplChar, 1'b1, 1'b1};
        // a byte that broke a sequence is decoded again from the start
        kind = was_mid ? take_byte(b, cp) : FEED_NONE;
        if (kind != FEED_NONE) first.last = 1'b0;
        pending_cps.push_back(first);
        if (kind == FEED_CODE) pending_cps.push_back('{cp, 1'b0, 1'b1});
        else if (kind == FEED_REJECT) pending_cps.push_back('{ReplChar, 1'b1, 1'b1});
      end
      if (eoi) begin
        cur_state = ST_ACCEPT;
        acc_code  = '0;
      end
    endfunction

    function void check(logic [CpW-1:0] cp, logic repl, logic last);
      cp_beat_t want;
      if (pending_cps.size() == 0) begin
        flag($sformatf("result beat with none expected: cp=%06h repl=%0b last=%0b",
                       cp, repl, last));
        return;
      end
      want = pending_cps.pop_front();
      if (want.cp !== cp || want.repl !== repl || want.last !== last)
        flag($sformatf("expected cp=%06h repl=%0b last=%0b, got cp=%06h repl=%0b last=%0b",
                       want.cp, want.repl, want.last, cp, repl, last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  cp_scoreboard sb = new();
  logic [7:0]   enc[$];
  int           bytes_sent = 0;
  int           idle_cycles = 0;
  bit           quiet = 1'b0;

  always #5 clk = ~clk;

  utf8_decode_with_replacement u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [CpW-1:0] rand_scalar();
    logic [CpW-1:0] v;
    if ($urandom_range(0, 7) == 0) return EdgeScalars[$urandom_range(0, 9)];
    case ($urandom_range(0, 3))
      0: v = CpW'($urandom_range(0, 'h7F));
      1: v = CpW'($urandom_range('h80, 'h7FF));
      2: begin
        v = CpW'($urandom_range('h800, 'hFFFF));
        if (v >= 'hD800 && v <= 'hDFFF) v = v ^ 21'h002000;
      end
      default: v = CpW'($urandom_range('h10000, 'h10FFFF));
    endcase
    return v;
  endfunction

  task automatic encode(logic [CpW-1:0] cp);
    enc = {};
    if (cp < 'h80) begin
      enc.push_back(cp[7:0]);
    end else if (cp < 'h800) begin
      enc.push_back({3'b110, cp[10:6]});
      enc.push_back({2'b10, cp[5:0]});
    end else if (cp < 'h10000) begin
      enc.push_back({4'b1110, cp[15:12]});
      enc.push_back({2'b10, cp[11:6]});
      enc.push_back({2'b10, cp[5:0]});
    end else begin
      enc.push_back({5'b11110, cp[20:18]});
      enc.push_back({2'b10, cp[17:12]});
      enc.push_back({2'b10, cp[11:6]});
      enc.push_back({2'b10, cp[5:0]});
    end
  endtask

  // entered and left at a falling edge
  task automatic send_byte(logic [7:0] b, logic eoi);
    int n;
    n = quiet ? 0 : gap_len();
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_enc(int keep, bit eoi_end);
    for (int i = 0; i < keep; i++) send_byte(enc[i], eoi_end && i == keep - 1);
  endtask

  // scoreboard hooks: the byte beat is noted before the result beat is checked
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check(m_tdata[CpW-1:0], m_tuser, m_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 2) == 0) stall_left = gap_len();
      end
    end
  end

  initial begin
    int mode;
    int keep;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (Directed[i]) send_byte(Directed[i][7:0], Directed[i][8]);

    while (bytes_sent < ByteCount) begin
      if ($urandom_range(0, 99) == 0) quiet = !quiet;
      mode = $urandom_range(0, 99);
      if (mode < 65) begin
        encode(rand_scalar());
        send_enc(enc.size(), $urandom_range(0, 29) == 0);
      end else if (mode < 75) begin
        // leads with a narrowed second-byte range, followed by any continuation
        enc = {};
        enc.push_back(RangedLeads[$urandom_range(0, 3)]);
        repeat ($urandom_range(1, 3)) enc.push_back(8'($urandom_range('h80, 'hBF)));
        send_enc(enc.size(), 1'b0);
      end else if (mode < 90) begin
        do encode(rand_scalar()); while (enc.size() < 2);
        keep = $urandom_range(1, enc.size() - 1);
        if (mode < 83) begin
          send_enc(keep, 1'b0);
          send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          send_enc(keep, 1'b1);
        end
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending_cps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
src/u8d_pkg.sv
src/u8d_core.sv
src/utf8_decode_with_replacement.sv
tb/tb_top.sv
